>>> hdl/gcsp_pkg.sv
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared types and codes of the generation checked slot pool: request
// operations, result status codes, the live tag and the classified request
// word passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package gcsp_pkg;

  // Pool size default
  localparam int unsigned SLOTS_DEFAULT = 1024;

  // Field widths fixed by the interface
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned TAG_W    = 3;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned TOTAL_W  = 32;

  // Action codes on the input port
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;

  // Classified operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_CHECK   = 2'd2;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_NULL  = 2'd2;
  localparam status_t ST_FAKE  = 2'd3;

  // Lifecycle tags
  localparam logic [TAG_W-1:0] TAG_LIVE = 3'd1;
  localparam logic [TAG_W-1:0] TAG_NONE = 3'd0;

  // Classified request word
  typedef struct packed {
    op_t              op;
    logic             is_null;
    logic             tag_live;
    logic             in_range;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } req_t;

  // Handshake between front-end queue and back end
  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctl_t;

endpackage

`default_nettype wire

>>> hdl/gcsp_front.sv
// ----------------------------------------------------------------------------
// gcsp_front
// Accepts request words, classifies them (operation, null, live tag, slot
// range) and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsp_front
  import gcsp_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic                in_handle_null,
  input  wire logic [TAG_W-1:0]    in_handle_tag,
  input  wire logic [SLOT_W-1:0]   in_handle_slot,
  input  wire logic [GEN_W-1:0]    in_handle_generation,
  input  wire back_ctl_t           back_ctl,
  output logic                     q_valid,
  output req_t                     q_head
);

  req_t        q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  logic        pop;
  req_t        req_c;

  // Classify the incoming word
  always_comb begin
    unique case (in_action)
      ACT_ALLOC:   req_c.op = OP_ALLOC;
      ACT_RELEASE: req_c.op = OP_RELEASE;
      default:     req_c.op = OP_CHECK;
    endcase
    req_c.is_null  = in_handle_null;
    req_c.tag_live = (in_handle_tag == TAG_LIVE);
    req_c.in_range = (32'(in_handle_slot) < 32'(SLOTS));
    req_c.slot     = in_handle_slot;
    req_c.gen      = in_handle_generation;
  end

  // Stall when the queue is full or the pool is still clearing
  assign in_stall = (cnt_r == 2'd2) || back_ctl.init_busy;
  assign push     = in_valid && !in_stall;
  assign pop      = back_ctl.pop;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_c;
    end
  end

endmodule

`default_nettype wire

>>> hdl/gcsp_back.sv
// ----------------------------------------------------------------------------
// gcsp_back
// Carries out queued requests against the link and generation memories:
// a read state reads them, then an execute state updates stack, counters
// and memories and loads the result register. Clears memories after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsp_back
  import gcsp_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire req_t               q_head,
  output back_ctl_t               back_ctl,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [GEN_W-1:0]        out_generation,
  output logic [TAG_W-1:0]        out_tag,
  output logic [COUNT_W-1:0]      out_free_count,
  output logic [COUNT_W-1:0]      out_live_count,
  output logic [TOTAL_W-1:0]      out_alloc_total,
  output logic [TOTAL_W-1:0]      out_release_total,
  output logic [TOTAL_W-1:0]      out_counterfeit_total,
  output logic [GEN_W-1:0]        out_highest_generation
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Memories
  logic [IW-1:0]    link_mem [SLOTS];
  logic [GEN_W-1:0] gen_mem  [SLOTS];

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [IW-1:0]      init_idx_r;
  req_t               cur_r;
  logic [IW-1:0]      link_rd_r;
  logic [GEN_W-1:0]   gen_rd_r;

  logic [IW-1:0]      top_r;
  logic [IW-1:0]      top_nxt;
  logic [FW-1:0]      free_r;
  logic [FW-1:0]      free_nxt;
  logic [TOTAL_W-1:0] alloc_r;
  logic [TOTAL_W-1:0] alloc_nxt;
  logic [TOTAL_W-1:0] rel_r;
  logic [TOTAL_W-1:0] rel_nxt;
  logic [TOTAL_W-1:0] fake_r;
  logic [TOTAL_W-1:0] fake_nxt;
  logic [GEN_W-1:0]   peak_r;
  logic [GEN_W-1:0]   peak_nxt;

  logic               out_valid_r;
  status_t            status_r;
  status_t            status_c;
  logic [SLOT_W-1:0]  rslot_r;
  logic [SLOT_W-1:0]  rslot_c;
  logic [GEN_W-1:0]   rgen_r;
  logic [GEN_W-1:0]   rgen_c;
  logic [TAG_W-1:0]   rtag_r;
  logic [TAG_W-1:0]   rtag_c;
  logic [COUNT_W-1:0] free_cnt_r;
  logic [COUNT_W-1:0] live_cnt_r;
  logic [31:0]        free_w;
  logic [31:0]        live_w;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               link_we;
  logic               gen_we;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      link_wd;
  logic [GEN_W-1:0]   gen_wd;
  logic               fire;
  logic               handle_ok;
  logic [IW-1:0]      cur_idx;

  assign cur_idx   = cur_r.slot[IW-1:0];
  assign handle_ok = cur_r.tag_live && cur_r.in_range && (cur_r.gen == gen_rd_r);
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Read side: top of stack for allocate, claimed slot otherwise
  assign rd_en   = (state_r == S_READ) && q_valid;
  assign rd_addr = (q_head.op == OP_ALLOC) ? top_r : q_head.slot[IW-1:0];

  assign back_ctl.pop       = rd_en;
  assign back_ctl.init_busy = (state_r == S_INIT);

  // Sequence clearing, read and execute
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (init_idx_r == IW'(SLOTS - 1)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (q_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Execute the request and work out the memory writes
  always_comb begin
    top_nxt   = top_r;
    free_nxt  = free_r;
    alloc_nxt = alloc_r;
    rel_nxt   = rel_r;
    fake_nxt  = fake_r;
    peak_nxt  = peak_r;
    status_c  = ST_OK;
    rslot_c   = '0;
    rgen_c    = '0;
    rtag_c    = TAG_NONE;
    link_we   = 1'b0;
    gen_we    = 1'b0;
    wr_addr   = cur_idx;
    link_wd   = '0;
    gen_wd    = cur_r.gen + GEN_W'(1);

    if (state_r == S_INIT) begin
      link_we = 1'b1;
      gen_we  = 1'b1;
      wr_addr = init_idx_r;
      link_wd = (init_idx_r == IW'(SLOTS - 1)) ? '0 : init_idx_r + IW'(1);
      gen_wd  = '0;
    end else if (fire) begin
      if (cur_r.op == OP_ALLOC) begin
        if (free_r == '0) begin
          status_c = ST_EMPTY;
        end else begin
          // Pop the top slot and cut its link
          top_nxt   = link_rd_r;
          free_nxt  = free_r - FW'(1);
          alloc_nxt = alloc_r + TOTAL_W'(1);
          if (gen_rd_r > peak_r) begin
            peak_nxt = gen_rd_r;
          end
          link_we = 1'b1;
          wr_addr = top_r;
          link_wd = '0;
          rslot_c = SLOT_W'(top_r);
          rgen_c  = gen_rd_r;
          rtag_c  = TAG_LIVE;
        end
      end else if (cur_r.is_null) begin
        status_c = ST_NULL;
      end else if (!handle_ok) begin
        status_c = ST_FAKE;
        fake_nxt = fake_r + TOTAL_W'(1);
      end else if (cur_r.op == OP_RELEASE) begin
        if (free_r == FW'(SLOTS)) begin
          status_c = ST_FAKE;
          fake_nxt = fake_r + TOTAL_W'(1);
        end else begin
          // Bump the generation and push the slot
          gen_we   = 1'b1;
          link_we  = 1'b1;
          link_wd  = top_r;
          top_nxt  = cur_idx;
          free_nxt = free_r + FW'(1);
          rel_nxt  = rel_r + TOTAL_W'(1);
          rslot_c  = cur_r.slot;
          rgen_c   = cur_r.gen;
          rtag_c   = TAG_LIVE;
        end
      end else begin
        rslot_c = cur_r.slot;
        rgen_c  = cur_r.gen;
        rtag_c  = TAG_LIVE;
      end
    end
  end

  assign free_w = 32'(free_nxt);
  assign live_w = 32'(SLOTS) - free_w;

  // Memory ports
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (gen_we) begin
      gen_mem[wr_addr] <= gen_wd;
    end
    if (rd_en) begin
      link_rd_r <= link_mem[rd_addr];
      gen_rd_r  <= gen_mem[rd_addr];
    end
  end

  // Hold the request under execution
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= q_head;
    end
  end

  // Control state and pool counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      top_r       <= '0;
      free_r      <= FW'(SLOTS);
      alloc_r     <= '0;
      rel_r       <= '0;
      fake_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        init_idx_r <= init_idx_r + IW'(1);
      end
      top_r   <= top_nxt;
      free_r  <= free_nxt;
      alloc_r <= alloc_nxt;
      rel_r   <= rel_nxt;
      fake_r  <= fake_nxt;
      peak_r  <= peak_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_c;
      rslot_r    <= rslot_c;
      rgen_r     <= rgen_c;
      rtag_r     <= rtag_c;
      free_cnt_r <= free_w[COUNT_W-1:0];
      live_cnt_r <= live_w[COUNT_W-1:0];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_slot               = rslot_r;
  assign out_generation         = rgen_r;
  assign out_tag                = rtag_r;
  assign out_free_count         = free_cnt_r;
  assign out_live_count         = live_cnt_r;
  assign out_alloc_total        = alloc_r;
  assign out_release_total      = rel_r;
  assign out_counterfeit_total  = fake_r;
  assign out_highest_generation = peak_r;

endmodule

`default_nettype wire

>>> hdl/generation_checked_slot_pool.sv
// ----------------------------------------------------------------------------
// generation_checked_slot_pool
// Pool of SLOTS slots with a LIFO free stack and a 16-bit generation per
// slot: allocate, release and check of generational handles.
// ----------------------------------------------------------------------------
// After reset the pool clears its link and generation memories, one slot a
// cycle, until all SLOTS slots are cleared; in_stall stays high meanwhile.
// Each request word then passes a read state, which reads the link and
// generation memories at the top of the stack or at the claimed slot, and
// an execute state, which updates stack, counters and memories. The next
// pop depends on the link read for the previous one, so a new word is read
// only once the previous one has executed. A two-word queue in front of the
// execution unit and a result register behind it let either side stall on
// its own. The counters shown with a result are those after that request;
// the counterfeit, release and allocation totals wrap at 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module generation_checked_slot_pool
  import gcsp_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic                in_handle_null,
  input  wire logic [TAG_W-1:0]    in_handle_tag,
  input  wire logic [SLOT_W-1:0]   in_handle_slot,
  input  wire logic [GEN_W-1:0]    in_handle_generation,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [GEN_W-1:0]         out_generation,
  output logic [TAG_W-1:0]         out_tag,
  output logic [COUNT_W-1:0]       out_free_count,
  output logic [COUNT_W-1:0]       out_live_count,
  output logic [TOTAL_W-1:0]       out_alloc_total,
  output logic [TOTAL_W-1:0]       out_release_total,
  output logic [TOTAL_W-1:0]       out_counterfeit_total,
  output logic [GEN_W-1:0]         out_highest_generation
);

  logic      q_valid;
  req_t      q_head;
  back_ctl_t back_ctl;

  // Accept and classify
  gcsp_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_handle_null       (in_handle_null),
    .in_handle_tag        (in_handle_tag),
    .in_handle_slot       (in_handle_slot),
    .in_handle_generation (in_handle_generation),
    .back_ctl             (back_ctl),
    .q_valid              (q_valid),
    .q_head               (q_head)
  );

  // Execute against the pool
  gcsp_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_head                 (q_head),
    .back_ctl               (back_ctl),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_slot               (out_slot),
    .out_generation         (out_generation),
    .out_tag                (out_tag),
    .out_free_count         (out_free_count),
    .out_live_count         (out_live_count),
    .out_alloc_total        (out_alloc_total),
    .out_release_total      (out_release_total),
    .out_counterfeit_total  (out_counterfeit_total),
    .out_highest_generation (out_highest_generation)
  );

endmodule

`default_nettype wire

>>> sim/generation_checked_slot_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_checked_slot_pool_tb
// Self-checking bench for the generational slot pool. Request words are
// built up front together with the reply each should produce, from a
// behavioural copy of the pool. A clocked driver feeds them through the
// valid/stall handshake. A clocked monitor checks every reply word, field
// by field, in order. Both sides stall in random bursts. The stimulus runs
// a short directed block, then mixed traffic, a full drain into the empty
// pool, release-heavy traffic, and a final quiet stretch.
// ----------------------------------------------------------------------------
module generation_checked_slot_pool_tb;
  import gcsp_pkg::*;

  localparam int unsigned POOL             = SLOTS_DEFAULT;
  localparam int unsigned HANG_LIMIT       = 4 * POOL + 1000;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned QUIET_WORDS      = 150;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned RESET_CYCLES     = 12;

  // Check codes on the action port; the spare code behaves as a check
  localparam logic [ACTION_W-1:0] ACT_CHECK     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CHECK_ALT = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic                is_null;
    logic [TAG_W-1:0]    tag;
    logic [SLOT_W-1:0]   slot;
    logic [GEN_W-1:0]    gen;
  } pool_cmd_t;

  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   gen;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] free_cnt;
    logic [COUNT_W-1:0] live_cnt;
    logic [TOTAL_W-1:0] allocs;
    logic [TOTAL_W-1:0] releases;
    logic [TOTAL_W-1:0] fakes;
    logic [GEN_W-1:0]   peak;
  } pool_reply_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic                in_handle_null = 1'b0;
  logic [TAG_W-1:0]    in_handle_tag = '0;
  logic [SLOT_W-1:0]   in_handle_slot = '0;
  logic [GEN_W-1:0]    in_handle_generation = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [GEN_W-1:0]    out_generation;
  logic [TAG_W-1:0]    out_tag;
  logic [COUNT_W-1:0]  out_free_count;
  logic [COUNT_W-1:0]  out_live_count;
  logic [TOTAL_W-1:0]  out_alloc_total;
  logic [TOTAL_W-1:0]  out_release_total;
  logic [TOTAL_W-1:0]  out_counterfeit_total;
  logic [GEN_W-1:0]    out_highest_generation;

  generation_checked_slot_pool #(
    .SLOTS(POOL)
  ) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_handle_null        (in_handle_null),
    .in_handle_tag         (in_handle_tag),
    .in_handle_slot        (in_handle_slot),
    .in_handle_generation  (in_handle_generation),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_slot              (out_slot),
    .out_generation        (out_generation),
    .out_tag               (out_tag),
    .out_free_count        (out_free_count),
    .out_live_count        (out_live_count),
    .out_alloc_total       (out_alloc_total),
    .out_release_total     (out_release_total),
    .out_counterfeit_total (out_counterfeit_total),
    .out_highest_generation(out_highest_generation)
  );

  always #2 clk = ~clk;

  // Behavioural pool: free-stack links, generations and counters
  logic [SLOT_W-1:0]  link_of [POOL];
  logic [GEN_W-1:0]   gen_of [POOL];
  int unsigned        top_slot;
  int unsigned        free_left;
  logic [TOTAL_W-1:0] alloc_cnt;
  logic [TOTAL_W-1:0] release_cnt;
  logic [TOTAL_W-1:0] fake_cnt;
  logic [GEN_W-1:0]   gen_peak;

  // Words to send with their replies, handles believed live, replies owed
  pool_cmd_t   words_to_send[$];
  pool_reply_t replies_to_send[$];
  handle_t     live_handles[$];
  pool_reply_t awaited[$];

  pool_reply_t reply_on_wire;
  bit          word_taken = 1'b0;
  int unsigned words_left = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned hang_cycles = 0;
  int unsigned mismatches = 0;

  function automatic void pool_clear();
    int i;
    for (i = 0; i < POOL; i++) begin
      link_of[i] = SLOT_W'((i + 1 < POOL) ? i + 1 : 0);
      gen_of[i]  = '0;
    end
    top_slot    = 0;
    free_left   = POOL;
    alloc_cnt   = '0;
    release_cnt = '0;
    fake_cnt    = '0;
    gen_peak    = '0;
  endfunction

  // Apply one request word to the behavioural pool and return its reply
  function automatic pool_reply_t serve_request(pool_cmd_t cmd);
    pool_reply_t rep;
    int unsigned pick;
    logic        genuine;
    rep = '{default: '0};
    rep.status = ST_OK;
    genuine = 1'b0;
    if (cmd.tag == TAG_LIVE && cmd.slot < POOL) genuine = (cmd.gen == gen_of[cmd.slot]);
    if (cmd.action == ACT_ALLOC) begin
      if (free_left == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        pick      = top_slot;
        rep.slot  = SLOT_W'(pick);
        rep.gen   = gen_of[pick];
        rep.tag   = TAG_LIVE;
        top_slot  = 32'(link_of[pick]);
        link_of[pick] = '0;
        free_left--;
        alloc_cnt++;
        if (gen_of[pick] > gen_peak) gen_peak = gen_of[pick];
      end
    end else if (cmd.is_null) begin
      rep.status = ST_NULL;
    end else if (!genuine || (cmd.action == ACT_RELEASE && free_left >= POOL)) begin
      // A release into a full pool cannot name a live slot
      rep.status = ST_FAKE;
      fake_cnt++;
    end else begin
      rep.slot = cmd.slot;
      rep.gen  = cmd.gen;
      rep.tag  = TAG_LIVE;
      if (cmd.action == ACT_RELEASE) begin
        gen_of[cmd.slot]  = cmd.gen + GEN_W'(1);
        link_of[cmd.slot] = SLOT_W'(top_slot);
        top_slot = 32'(cmd.slot);
        free_left++;
        release_cnt++;
      end
    end
    rep.free_cnt = COUNT_W'(free_left);
    rep.live_cnt = COUNT_W'(POOL - free_left);
    rep.allocs   = alloc_cnt;
    rep.releases = release_cnt;
    rep.fakes    = fake_cnt;
    rep.peak     = gen_peak;
    return rep;
  endfunction

  function automatic pool_cmd_t make_cmd(logic [ACTION_W-1:0] action, logic is_null,
                                         logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] slot,
                                         logic [GEN_W-1:0] gen);
    pool_cmd_t cmd;
    cmd.action  = action;
    cmd.is_null = is_null;
    cmd.tag     = tag;
    cmd.slot    = slot;
    cmd.gen     = gen;
    return cmd;
  endfunction

  // Allocate; the handle fields are ignored, so fill them with junk
  function automatic pool_cmd_t alloc_cmd();
    return make_cmd(ACT_ALLOC, 1'($urandom), TAG_W'($urandom), SLOT_W'($urandom),
                    GEN_W'($urandom));
  endfunction

  function automatic handle_t pick_live();
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // Queue a word with its reply and keep the live handle list in step
  function automatic pool_reply_t queue_word(pool_cmd_t cmd);
    pool_reply_t rep;
    handle_t     h;
    int          k;
    rep = serve_request(cmd);
    words_to_send.push_back(cmd);
    replies_to_send.push_back(rep);
    h.slot = rep.slot;
    h.gen  = rep.gen;
    if (rep.status == ST_OK && cmd.action == ACT_ALLOC) begin
      live_handles.push_back(h);
    end else if (rep.status == ST_OK && cmd.action == ACT_RELEASE) begin
      // Newest handles sit at the back; search from there
      for (k = live_handles.size() - 1; k >= 0; k--) begin
        if (live_handles[k].slot == h.slot && live_handles[k].gen == h.gen) begin
          live_handles.delete(k);
          break;
        end
      end
    end
    return rep;
  endfunction

  // Malformed or hostile handle: null, wrong tag, stale, out of range, forged
  function automatic pool_cmd_t noise_cmd(bit forge_ok);
    handle_t             h;
    logic [ACTION_W-1:0] act;
    logic [TAG_W-1:0]    bad_tag;
    int unsigned         s;
    if (live_handles.size() > 0) begin
      h = pick_live();
    end else begin
      h.slot = SLOT_W'($urandom_range(0, POOL - 1));
      h.gen  = gen_of[h.slot];
    end
    act = ACTION_W'($urandom_range(1, 3));
    bad_tag = TAG_W'($urandom_range(0, 6));
    if (bad_tag >= TAG_LIVE) bad_tag++;
    case ($urandom_range(0, forge_ok ? 5 : 4))
      0: return make_cmd(ACTION_W'($urandom), 1'($urandom), TAG_W'($urandom),
                         SLOT_W'($urandom), GEN_W'($urandom));
      1: return make_cmd(act, 1'b1, TAG_W'($urandom), SLOT_W'($urandom), GEN_W'($urandom));
      2: return make_cmd(act, 1'b0, TAG_LIVE, h.slot, h.gen ^ (16'd1 << $urandom_range(0, 15)));
      3: return make_cmd(act, 1'b0, bad_tag, h.slot, h.gen);
      4: return make_cmd(act, 1'b0, TAG_LIVE, SLOT_W'($urandom_range(POOL, 16'hFFFF)), h.gen);
      default: begin
        s = $urandom_range(0, POOL - 1);
        return make_cmd(act, 1'b0, TAG_LIVE, SLOT_W'(s), gen_of[s]);
      end
    endcase
  endfunction

  // Mostly well-formed traffic on live handles, with some noise
  task automatic queue_mix(int unsigned count, int unsigned alloc_pct,
                           int unsigned release_pct, bit forge_ok);
    int unsigned n;
    int unsigned r;
    handle_t     h;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct || (live_handles.size() == 0 && r < alloc_pct + release_pct + 12)) begin
        void'(queue_word(alloc_cmd()));
      end else if (r < alloc_pct + release_pct) begin
        h = pick_live();
        void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, h.slot, h.gen)));
      end else if (r < alloc_pct + release_pct + 12) begin
        h = pick_live();
        void'(queue_word(make_cmd($urandom_range(0, 1) ? ACT_CHECK : ACT_CHECK_ALT,
                                  1'b0, TAG_LIVE, h.slot, h.gen)));
      end else begin
        void'(queue_word(noise_cmd(forge_ok)));
      end
    end
  endtask

  task automatic build_stimulus();
    handle_t     probe;
    pool_clear();

    // Directed: first handles, checks, null and counterfeit rejections, full pool, forgery
    void'(queue_word(alloc_cmd()));
    void'(queue_word(alloc_cmd()));
    void'(queue_word(alloc_cmd()));
    void'(queue_word(make_cmd(ACT_CHECK, 1'b0, TAG_LIVE, 16'd1, 16'd0)));
    void'(queue_word(make_cmd(ACT_CHECK_ALT, 1'b0, TAG_LIVE, 16'd2, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b1, TAG_LIVE, 16'd0, 16'd0)));
    void'(queue_word(make_cmd(ACT_CHECK, 1'b1, TAG_LIVE, 16'd1, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_NONE, 16'd0, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, 3'd7, 16'd0, 16'd0)));
    void'(queue_word(make_cmd(ACT_CHECK, 1'b0, TAG_LIVE, 16'hFFFF, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, SLOT_W'(POOL), 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd0, 16'hFFFF)));
    void'(queue_word(make_cmd(ACT_CHECK, 1'b0, TAG_LIVE, 16'd0, 16'd1)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd0, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd1, 16'd0)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd2, 16'd0)));
    // Pool is full: a valid-looking release must be refused
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd5, 16'd0)));
    void'(queue_word(make_cmd(ACT_ALLOC, 1'b1, '1, '1, '1)));
    // Forge a release of the bottom free slot, then use it and move on
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, SLOT_W'(POOL - 1), 16'd0)));
    void'(queue_word(make_cmd(ACT_CHECK, 1'b0, TAG_LIVE, SLOT_W'(POOL - 1), 16'd1)));
    void'(queue_word(make_cmd(ACT_RELEASE, 1'b0, TAG_LIVE, 16'd2, 16'd1)));
    void'(queue_word(alloc_cmd()));

    // Mixed traffic, forgeries allowed; the drain below repairs the stack
    queue_mix(150, 45, 30, 1'b1);

    // Drain to empty with the odd check, then knock on the empty pool
    while (free_left > 0) begin
      if ($urandom_range(0, 99) < 5 && live_handles.size() > 0) begin
        probe = pick_live();
        void'(queue_word(make_cmd(ACT_CHECK, 1'b0, TAG_LIVE, probe.slot, probe.gen)));
      end else begin
        void'(queue_word(alloc_cmd()));
      end
    end
    repeat (4) void'(queue_word(alloc_cmd()));

    queue_mix(150, 25, 50, 1'b0);

    queue_mix(100, 35, 35, 1'b0);
  endtask

  // Present request words; hold each until it is taken
  always @(negedge clk) begin
    pool_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (in_gap == 0 && words_left > QUIET_WORDS && $urandom_range(0, 99) < 10)
        in_gap = $urandom_range(1, 7);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        cmd = words_to_send.pop_front();
        reply_on_wire = replies_to_send.pop_front();
        in_action            <= cmd.action;
        in_handle_null       <= cmd.is_null;
        in_handle_tag        <= cmd.tag;
        in_handle_slot       <= cmd.slot;
        in_handle_generation <= cmd.gen;
        in_valid             <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the reply side in bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (rst_n && words_left > QUIET_WORDS && $urandom_range(0, 99) < 10) begin
      out_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Check replies against the oldest owed reply; record taken words
  always @(posedge clk) begin
    pool_reply_t want;
    if (rst_n) begin
      hang_cycles++;
      if (out_valid && !out_stall) begin
        hang_cycles = 0;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: reply word with none outstanding", $time);
        end else begin
          want = awaited.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("generation", 32'(want.gen), 32'(out_generation));
          check_field("tag", 32'(want.tag), 32'(out_tag));
          check_field("free_count", 32'(want.free_cnt), 32'(out_free_count));
          check_field("live_count", 32'(want.live_cnt), 32'(out_live_count));
          check_field("alloc_total", want.allocs, out_alloc_total);
          check_field("release_total", want.releases, out_release_total);
          check_field("counterfeit_total", want.fakes, out_counterfeit_total);
          check_field("highest_generation", 32'(want.peak), 32'(out_highest_generation));
        end
      end
      if (in_valid && !in_stall) begin
        hang_cycles = 0;
        word_taken = 1'b1;
        words_left--;
        awaited.push_back(reply_on_wire);
      end
      if (hang_cycles >= HANG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    words_left = words_to_send.size();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Wait for every word to be taken and answered, then let the pool settle
    do @(negedge clk); while (words_left > 0 || awaited.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
